@@ rtl/drs_pkg.sv @@
// ----------------------------------------------------------------------------
// Drop/repeat resampler package
// Shared widths, register map, reset values and the types that pass between
// the resampler's modules.
// ----------------------------------------------------------------------------
`default_nettype none

package drs_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int RATE_W     = 16;
   localparam int PHASE_W    = 17;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 2;

   // Register indexes (byte address = 4 * index).
   localparam logic [REG_IDX_W-1:0] REG_SOURCE_RATE = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_OUTPUT_RATE = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_STEREO_MODE = 2'd2;

   localparam logic [RATE_W-1:0] RATE_MIN       = 16'd8000;
   localparam logic [RATE_W-1:0] RATE_MAX       = 16'd48000;
   localparam logic [RATE_W-1:0] SOURCE_RATE_RST = 16'd22050;
   localparam logic [RATE_W-1:0] OUTPUT_RATE_RST = 16'd44100;

   // Operations of the shared phase unit.
   localparam logic ALU_SUB = 1'b0;
   localparam logic ALU_ADD = 1'b1;

   typedef struct packed {
      logic [RATE_W-1:0] source_rate;   // saturated to RATE_MIN..RATE_MAX
      logic [RATE_W-1:0] output_rate;   // saturated to RATE_MIN..RATE_MAX
      logic              stereo_mode;
   } cfg_type;

   typedef struct packed {
      logic               op;
      logic [PHASE_W-1:0] phase;
      logic [RATE_W-1:0]  rate;
   } alu_req_type;

   typedef struct packed {
      logic [PHASE_W-1:0] result;
      logic               ge;           // phase >= rate on a subtract
   } alu_rsp_type;

endpackage

`default_nettype wire

@@ rtl/drs_req_if.sv @@
// ----------------------------------------------------------------------------
// Resampler request channel
// Valid/ready channel that carries one source PCM frame per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface drs_req_if import drs_pkg::*; ();

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] left_in;
   logic signed [SAMPLE_W-1:0] right_in;
   logic                       block_end;
   logic                       restart;

   modport source (output valid, output left_in, output right_in, output block_end,
                   output restart, input ready);
   modport sink   (input valid, input left_in, input right_in, input block_end,
                   input restart, output ready);

endinterface

`default_nettype wire

@@ rtl/drs_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Resampler response channel
// Valid/ready channel that carries one output PCM frame per response.
// ----------------------------------------------------------------------------
`default_nettype none

interface drs_rsp_if import drs_pkg::*; ();

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] left_out;
   logic signed [SAMPLE_W-1:0] right_out;
   logic                       run_last;

   modport source (output valid, output left_out, output right_out, output run_last,
                   input ready);
   modport sink   (input valid, input left_out, input right_out, input run_last,
                   output ready);

endinterface

`default_nettype wire

@@ rtl/drs_csr.sv @@
// ----------------------------------------------------------------------------
// Resampler control registers
// APB-style register file holding the two rates and the stereo flag, with
// the rates saturated to the legal range on their way to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module drs_csr import drs_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output      logic [CSR_DATA_W-1:0] prdata,
   output      logic                  pready,
   output      cfg_type               cfg
);

   logic [RATE_W-1:0]    source_rate_ff, source_rate_in;
   logic [RATE_W-1:0]    output_rate_ff, output_rate_in;
   logic                 stereo_mode_ff, stereo_mode_in;
   logic [REG_IDX_W-1:0] reg_idx;
   logic                 wr_en;

   function automatic logic [RATE_W-1:0] clamp_rate(input logic [RATE_W-1:0] r);
      logic [RATE_W-1:0] v;
      if (r < RATE_MIN)      v = RATE_MIN;
      else if (r > RATE_MAX) v = RATE_MAX;
      else                   v = r;
      return v;
   endfunction

   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;

   always_comb begin
      source_rate_in = source_rate_ff;
      output_rate_in = output_rate_ff;
      stereo_mode_in = stereo_mode_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_SOURCE_RATE: source_rate_in = pwdata[RATE_W-1:0];
            REG_OUTPUT_RATE: output_rate_in = pwdata[RATE_W-1:0];
            REG_STEREO_MODE: stereo_mode_in = pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_SOURCE_RATE: prdata = {{(CSR_DATA_W-RATE_W){1'b0}}, source_rate_ff};
         REG_OUTPUT_RATE: prdata = {{(CSR_DATA_W-RATE_W){1'b0}}, output_rate_ff};
         REG_STEREO_MODE: prdata = {{(CSR_DATA_W-1){1'b0}}, stereo_mode_ff};
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         source_rate_ff <= SOURCE_RATE_RST;
         output_rate_ff <= OUTPUT_RATE_RST;
         stereo_mode_ff <= 1'b1;
      end else begin
         source_rate_ff <= source_rate_in;
         output_rate_ff <= output_rate_in;
         stereo_mode_ff <= stereo_mode_in;
      end
   end

   assign cfg.source_rate = clamp_rate(source_rate_ff);
   assign cfg.output_rate = clamp_rate(output_rate_ff);
   assign cfg.stereo_mode = stereo_mode_ff;

endmodule

`default_nettype wire

@@ rtl/drs_alu.sv @@
// ----------------------------------------------------------------------------
// Resampler phase unit
// The single adder/subtractor shared by every step of the phase sequence.
// A subtract also reports whether the phase reached the rate operand.
// ----------------------------------------------------------------------------
`default_nettype none

module drs_alu import drs_pkg::*; (
   input  wire alu_req_type req,
   output      alu_rsp_type rsp
);

   logic [PHASE_W:0]   diff;
   logic [PHASE_W-1:0] sum;

   assign diff = {1'b0, req.phase} - {2'b00, req.rate};
   assign sum  = req.phase + {1'b0, req.rate};

   always_comb begin
      rsp.ge = ~diff[PHASE_W];
      unique case (req.op)
         ALU_ADD: rsp.result = sum;
         ALU_SUB: rsp.result = diff[PHASE_W-1:0];
         default: rsp.result = diff[PHASE_W-1:0];
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/drop_repeat_audio_resampler_top.sv @@
// ----------------------------------------------------------------------------
// Drop/repeat audio resampler
// Nearest-neighbor rate converter that skips or repeats source frames under
// a phase accumulator, with an APB-style register port.
// ----------------------------------------------------------------------------
// Each request is one source PCM frame. A 17-bit phase accumulator decides
// whether the frame is dropped (no response) or sent out one to six times;
// the last response of a run carries run_last. Both rates saturate to
// 8000..48000 Hz, a restart request clears the phase before its frame is
// used and a block_end request clears it afterwards. In mono mode the right
// sample repeats the left one. The block works on one request at a time and
// all phase arithmetic goes through one shared 17-bit add/subtract unit, one
// operation per cycle unless a response waits on the port: a request is
// accepted in idle and then goes through the skip test, and each response
// then takes an add step, a compare step and a wait on the response port
// until response ready is high. A dropped frame ends after the skip test.
// Request ready is high only while the block is idle. Registers may be
// written only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module drop_repeat_audio_resampler_top import drs_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   drs_req_if.sink                    req_chan,
   drs_rsp_if.source                  rsp_chan,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output      logic [CSR_DATA_W-1:0] csr_prdata,
   output      logic                  csr_pready
);

   // Sequencer states.
   localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a request
   localparam logic [2:0] S_TEST = 3'd1;  // skip test: phase >= output_rate
   localparam logic [2:0] S_ADD  = 3'd2;  // phase += source_rate
   localparam logic [2:0] S_CMP  = 3'd3;  // decide whether this response ends the run
   localparam logic [2:0] S_OUT  = 3'd4;  // response held until taken

   // The phase never exceeds the largest output rate plus the largest source rate.
   localparam logic [PHASE_W-1:0] PHASE_BOUND = 17'd96000;

   cfg_type     cfg;
   alu_req_type alu_req;
   alu_rsp_type alu_rsp;

   logic [2:0]                 state_ff, state_in;
   logic [PHASE_W-1:0]         phase_ff, phase_in;
   logic signed [SAMPLE_W-1:0] left_ff, left_in;
   logic signed [SAMPLE_W-1:0] right_ff, right_in;
   logic                       end_ff, end_in;
   logic                       last_ff, last_in;
   logic                       req_fire;
   logic                       rsp_fire;

   drs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   drs_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid & req_chan.ready;
   assign rsp_chan.valid = (state_ff == S_OUT);
   assign rsp_fire       = rsp_chan.valid & rsp_chan.ready;

   assign rsp_chan.left_out  = left_ff;
   assign rsp_chan.right_out = right_ff;
   assign rsp_chan.run_last  = last_ff;

   // The shared unit adds source_rate only in the add state; every other
   // state compares against output_rate and offers the difference.
   always_comb begin
      alu_req.phase = phase_ff;
      if (state_ff == S_ADD) begin
         alu_req.op   = ALU_ADD;
         alu_req.rate = cfg.source_rate;
      end else begin
         alu_req.op   = ALU_SUB;
         alu_req.rate = cfg.output_rate;
      end
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      left_in  = left_ff;
      right_in = right_ff;
      end_in   = end_ff;
      last_in  = last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               left_in  = req_chan.left_in;
               right_in = cfg.stereo_mode ? req_chan.right_in : req_chan.left_in;
               end_in   = req_chan.block_end;
               if (req_chan.restart) begin
                  phase_in = '0;
               end
               state_in = S_TEST;
            end
         end
         S_TEST: begin
            // A phase already at or past the threshold drops the frame.
            if (alu_rsp.ge) begin
               phase_in = end_ff ? '0 : alu_rsp.result;
               state_in = S_IDLE;
            end else begin
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            phase_in = alu_rsp.result;
            state_in = S_CMP;
         end
         S_CMP: begin
            // Reaching the threshold ends the run; the one subtraction of
            // output_rate happens here.
            last_in = alu_rsp.ge;
            if (alu_rsp.ge) begin
               phase_in = end_ff ? '0 : alu_rsp.result;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_fire) begin
               state_in = last_ff ? S_IDLE : S_ADD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff  <= left_in;
      right_ff <= right_in;
      end_ff   <= end_in;
      last_ff  <= last_in;
   end

   // A new request is never taken while a response is still on offer.
   assert property (@(posedge clock) disable iff (reset)
      req_chan.ready |-> !rsp_chan.valid)
      else $error("request accepted while a response is pending");

   // A response that does not end its run is followed by more work, not by idle.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && !rsp_chan.run_last) |=> (!req_chan.ready && !rsp_chan.valid))
      else $error("run ended without a run_last response");

   // The accumulator stays within the bound set by the saturated rates.
   assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PHASE_BOUND)
      else $error("phase accumulator out of range");

   // Each repeat step starts from a phase below the threshold.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ADD) |-> (phase_ff < {1'b0, cfg.output_rate}))
      else $error("repeat step entered with phase at or above output rate");

endmodule

`default_nettype wire

@@ dv/drs_resampler_checker.sv @@
// ----------------------------------------------------------------------------
// Drop/repeat resampler checker
// Watches the register port and both frame channels, predicts every output
// frame from its own copy of the rate registers and the phase, and compares
// each accepted response field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module drs_resampler_checker import drs_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   drs_req_if                         req_mon,
   drs_rsp_if                         rsp_mon,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   input  wire logic                  csr_pready,
   output int                         mismatches,
   output int                         frames_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_REPEATS = 6;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
      logic                       run_last;
   } out_frame_type;

   out_frame_type      pending_frames[$];
   out_frame_type      oldest;
   logic [RATE_W-1:0]  source_rate_reg;
   logic [RATE_W-1:0]  output_rate_reg;
   logic               stereo_reg;
   logic [PHASE_W-1:0] phase;

   function automatic int unsigned saturate_rate(logic [RATE_W-1:0] rate);
      if (rate < RATE_MIN) return RATE_MIN;
      if (rate > RATE_MAX) return RATE_MAX;
      return rate;
   endfunction

   // Advances the phase by one source frame and queues the frames it emits.
   task automatic resample_frame(input logic signed [SAMPLE_W-1:0] left_in,
                                 input logic signed [SAMPLE_W-1:0] right_in,
                                 input logic block_end, input logic restart);
      int unsigned   src;
      int unsigned   dst;
      int unsigned   ph;
      int            count;
      out_frame_type frame;
      src = saturate_rate(source_rate_reg);
      dst = saturate_rate(output_rate_reg);
      ph = phase;
      count = 0;
      frame.left = left_in;
      frame.right = stereo_reg ? right_in : left_in;
      if (restart) ph = 0;
      if (ph >= dst) begin
         ph = ph - dst;
      end else begin
         do begin
            count++;
            ph = ph + src;
            frame.run_last = (ph >= dst) || (count == MAX_REPEATS);
            pending_frames.push_back(frame);
         end while (!frame.run_last);
         if (ph >= dst) ph = ph - dst;
      end
      if (block_end) ph = 0;
      phase = ph[PHASE_W-1:0];
   endtask

   initial mismatches = 0;

   always @(posedge clock) begin
      if (reset) begin
         source_rate_reg = SOURCE_RATE_RST;
         output_rate_reg = OUTPUT_RATE_RST;
         stereo_reg = 1'b1;
         phase = '0;
         pending_frames.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[CSR_ADDR_W-1:2])
               REG_SOURCE_RATE: source_rate_reg = csr_pwdata[RATE_W-1:0];
               REG_OUTPUT_RATE: output_rate_reg = csr_pwdata[RATE_W-1:0];
               REG_STEREO_MODE: stereo_reg = csr_pwdata[0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            resample_frame(req_mon.left_in, req_mon.right_in, req_mon.block_end,
                           req_mon.restart);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_frames.size() == 0) begin
               $error("response with no frame expected: left_out %0d right_out %0d",
                      rsp_mon.left_out, rsp_mon.right_out);
               mismatches++;
            end else begin
               oldest = pending_frames.pop_front();
               if (rsp_mon.left_out !== oldest.left) begin
                  $error("left_out: expected %0d, got %0d", oldest.left, rsp_mon.left_out);
                  mismatches++;
               end
               if (rsp_mon.right_out !== oldest.right) begin
                  $error("right_out: expected %0d, got %0d", oldest.right,
                         rsp_mon.right_out);
                  mismatches++;
               end
               if (rsp_mon.run_last !== oldest.run_last) begin
                  $error("run_last: expected %0b, got %0b", oldest.run_last,
                         rsp_mon.run_last);
                  mismatches++;
               end
            end
         end
      end
      frames_owed = pending_frames.size();
   end

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// Drop/repeat resampler testbench
// Drives source frames and register writes into the resampler, stalls the
// response side at random, and leaves prediction and comparison to the
// checker that sits beside the block.
// ----------------------------------------------------------------------------
`default_nettype none

module tb import drs_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   // The address decoder has one slot past the register list; writes there
   // must be ignored.
   localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int RANDOM_PHASES = 8;
   localparam int FRAMES_PER_PHASE = 24;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   wire  [CSR_DATA_W-1:0] csr_prdata;
   wire                   csr_pready;

   int fail_count;
   int frames_owed;
   int quiet_cycles;
   // When set, neither side inserts idle cycles, so back-to-back traffic is
   // exercised as well.
   bit steady;

   drs_req_if req_chan ();
   drs_rsp_if rsp_chan ();

   drop_repeat_audio_resampler_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   drs_resampler_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .mismatches  (fail_count),
      .frames_owed (frames_owed)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Idle stretch length: mostly none, often a few cycles, rarely a long one.
   function automatic int idle_cycles();
      int pick;
      if (steady) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      if (pick < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Rate values: the saturation edges, usual audio rates, or any 16-bit value.
   function automatic logic [RATE_W-1:0] pick_rate();
      case ($urandom_range(0, 9))
         0: return 16'd0;
         1: return 16'd65535;
         2: return RATE_MIN;
         3: return RATE_MAX;
         4: return ($urandom_range(0, 1) != 0) ? 16'd7999 : 16'd48001;
         5: return 16'd11025;
         6: return ($urandom_range(0, 1) != 0) ? 16'd22050 : 16'd44100;
         7: return ($urandom_range(0, 1) != 0) ? 16'd16000 : 16'd32000;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // The response side alternates ready-low stalls with ready-high bursts.
   // Every change happens at a falling edge, and only once per edge.
   initial begin
      int stall;
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      forever begin
         stall = idle_cycles();
         if (stall > 0) begin
            rsp_chan.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready = 1'b1;
         if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 60)) @(negedge clock);
         else repeat ($urandom_range(1, 8)) @(negedge clock);
      end
   end

   // The watchdog ends the run once nothing at all has moved for too long.
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // One register write: a setup phase, then an access phase that completes
   // at the rising edge where pready is seen high.
   task automatic csr_write(input logic [REG_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = CSR_ADDR_W'(index) << 2;
      csr_pwdata = data;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   // Presents one source frame as a request and holds it until accepted.
   // With no idle cycles to follow, valid stays high into the next request.
   task automatic send_frame(input logic signed [SAMPLE_W-1:0] left_in,
                             input logic signed [SAMPLE_W-1:0] right_in,
                             input logic block_end, input logic restart);
      int gap;
      @(negedge clock);
      req_chan.valid = 1'b1;
      req_chan.left_in = left_in;
      req_chan.right_in = right_in;
      req_chan.block_end = block_end;
      req_chan.restart = restart;
      do @(posedge clock); while (!req_chan.ready);
      gap = idle_cycles();
      if (gap > 0) begin
         @(negedge clock);
         req_chan.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Waits until every predicted frame has come out and the block is back to
   // idle, which its request ready signals. A dropped frame produces nothing,
   // so the ready check and the extra cycles cover its short tail.
   task automatic settle();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (frames_owed != 0 || !req_chan.ready) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_rates(input logic [RATE_W-1:0] source_rate,
                            input logic [RATE_W-1:0] output_rate,
                            input logic stereo_mode);
      settle();
      csr_write(REG_SOURCE_RATE, CSR_DATA_W'(source_rate));
      csr_write(REG_OUTPUT_RATE, CSR_DATA_W'(output_rate));
      csr_write(REG_STEREO_MODE, CSR_DATA_W'(stereo_mode));
   endtask

   initial begin
      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      req_chan.valid = 1'b0;
      req_chan.left_in = '0;
      req_chan.right_in = '0;
      req_chan.block_end = 1'b0;
      req_chan.restart = 1'b0;
      quiet_cycles = 0;
      steady = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset rates give an exact two-to-one repeat. Sample extremes, a
      // block end, a restart, and a restart that comes with a block end.
      send_frame(16'sh7fff, -16'sd32768, 1'b0, 1'b0);
      send_frame(-16'sd32768, 16'sh7fff, 1'b0, 1'b0);
      send_frame(16'sd0, -16'sd1, 1'b1, 1'b0);
      send_frame(-16'sd1, 16'sd0, 1'b0, 1'b1);
      send_frame(16'sh5555, -16'sh5556, 1'b1, 1'b1);

      // A zero source rate saturates to the minimum against the maximum
      // output rate: the longest run of repeats. Mono mode copies left.
      set_rates(16'd0, RATE_MAX, 1'b0);
      send_frame(16'sh1234, 16'sh5678, 1'b0, 1'b0);
      send_frame(-16'sh1234, 16'sh0f0f, 1'b0, 1'b1);
      send_frame(16'sh00ff, -16'sh00ff, 1'b1, 1'b0);

      // Both rates saturate the other way: one frame out, then five skipped.
      // A restart after a skip and a block end cut the skipping short.
      set_rates(16'hffff, 16'd0, 1'b1);
      send_frame(16'sd1, 16'sd2, 1'b0, 1'b0);
      send_frame(16'sd3, 16'sd4, 1'b0, 1'b0);
      send_frame(16'sd5, 16'sd6, 1'b0, 1'b0);
      send_frame(16'sd7, 16'sd8, 1'b0, 1'b1);
      send_frame(16'sd9, 16'sd10, 1'b0, 1'b0);
      send_frame(16'sd11, 16'sd12, 1'b1, 1'b0);
      send_frame(16'sd13, 16'sd14, 1'b0, 1'b0);

      // Just outside the range on both sides, and a write past the register
      // list that must leave every register as it is.
      set_rates(16'd7999, 16'd48001, 1'b1);
      csr_write(REG_UNMAPPED, 32'h0000_1f40);
      send_frame(16'sh7ffe, -16'sh7fff, 1'b0, 1'b0);
      send_frame(-16'sh0001, 16'sh4000, 1'b0, 1'b0);

      // Downsampling by two: one frame out, the next dropped. The phase is
      // carried over from the previous setting on purpose.
      set_rates(16'd44100, 16'd22050, 1'b0);
      send_frame(16'sh0a0a, 16'sh0b0b, 1'b0, 1'b0);
      send_frame(16'sh0c0c, 16'sh0d0d, 1'b0, 1'b0);
      send_frame(16'sh0e0e, 16'sh0f0f, 1'b0, 1'b0);
      send_frame(-16'sh2000, 16'sh2000, 1'b1, 1'b0);

      // Random part: every phase picks new rates and channel mode without a
      // restart, so the phase runs across the change.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         set_rates(pick_rate(), pick_rate(), 1'($urandom_range(0, 1)));
         steady = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < FRAMES_PER_PHASE; k++) begin
            send_frame(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                       ($urandom_range(0, 9) == 0), ($urandom_range(0, 19) == 0));
         end
         steady = 1'b0;
      end

      settle();
      repeat (20) @(negedge clock);
      if (fail_count == 0 && frames_owed == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ files.f @@
rtl/drs_pkg.sv
rtl/drs_req_if.sv
rtl/drs_rsp_if.sv
rtl/drs_csr.sv
rtl/drs_alu.sv
rtl/drop_repeat_audio_resampler_top.sv
dv/drs_resampler_checker.sv
dv/tb.sv
